[rtl/frame_rotate_quarter_turn_macros.svh]
// Assertion macros used by the checker file frq_checker.sv.
// Expects signals named clk and rst in the scope of use.
`ifndef FRAME_ROTATE_QUARTER_TURN_MACROS_SVH
`define FRAME_ROTATE_QUARTER_TURN_MACROS_SVH

// Checked outside reset only.
`define FRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/frq_pkg.sv]
// Shared widths, codes and defaults for the quarter-turn frame rotator.
// No dependencies.
`timescale 1ns / 1ps

package frq_pkg;

  localparam int DIM_W      = 9;
  localparam int COORD_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int OFS_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int LANES      = 4;
  localparam int PIX_BYTES  = 3;
  localparam int ROW_ALIGN  = 4;
  localparam int MAX_DIM_DEFAULT = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TURN   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef enum logic {
    TURN_90  = 1'b0,
    TURN_270 = 1'b1
  } turn_t;

endpackage

[rtl/frq_if.sv]
// Valid/ready channel interfaces: pixel/read items in, result items out, config writes.
// Depends on frq_pkg.
`timescale 1ns / 1ps

interface frq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [frq_pkg::COORD_W-1:0]  src_col;
  logic [frq_pkg::COORD_W-1:0]  src_row;
  logic [frq_pkg::BYTE_W-1:0]   blue;
  logic [frq_pkg::BYTE_W-1:0]   green;
  logic [frq_pkg::BYTE_W-1:0]   red;
  logic [frq_pkg::COORD_W-1:0]  dst_row;
  logic [frq_pkg::OFS_W-1:0]    dst_byte;

  modport source (output valid, command, src_col, src_row, blue, green, red,
                  dst_row, dst_byte, input ready);
  modport sink (input valid, command, src_col, src_row, blue, green, red,
                dst_row, dst_byte, output ready);
endinterface

interface frq_out_if;
  logic                        valid;
  logic                        ready;
  logic [frq_pkg::BYTE_W-1:0]  read_data;
  logic                        range_error;

  modport source (output valid, read_data, range_error, input ready);
  modport sink (input valid, read_data, range_error, output ready);
endinterface

interface frq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frq_pkg::CFG_IDX_W-1:0]   index;
  logic [frq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/frq_lane_ram.sv]
// One byte lane of the frame store: one write port, one registered read port.
// Depends on frq_pkg for the byte width.
`timescale 1ns / 1ps

module frq_lane_ram #(
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [frq_pkg::BYTE_W-1:0]  wdata,
  input  logic                        re,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [frq_pkg::BYTE_W-1:0]  rdata
);

  logic [frq_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/frame_rotate_quarter_turn.sv]
// Top level of the quarter-turn frame rotator.
// Depends on frq_pkg, frq_if (channel interfaces) and frq_lane_ram.
// ---------------------------------------------------------------------------
// Channels: din takes items (command 0 writes a source pixel at src_col/src_row,
// command 1 reads one byte of the rotated frame at dst_row/dst_byte); dout
// returns one item per input item (read_data, range_error); cfg writes
// image_width (index 0), image_height (index 1), turn_direction (index 2).
// Sizes are clamped to 1..MAX_DIM when written. cfg is always ready; the user must
// write it only while no item is in flight, as the block does not enforce this.
// The frame store is four byte-lane RAMs addressed by linear byte address / 4,
// so the three bytes of a pixel land in the same cycle on three distinct lanes.
// Pipeline: input register, address register (one multiply-add), then the RAM
// read register alongside the output register, its lane muxed to dout.read_data.
// Throughput is one item per cycle while dout does not stall.
// When dout stalls, the whole pipeline holds and din.ready drops in the same
// cycle. Reset clears the pipeline valids and sets width=1, height=1, 90-degree
// mode; the store keeps its contents and is undefined until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_rotate_quarter_turn #(
  parameter int MAX_DIM = frq_pkg::MAX_DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  frq_in_if.sink     din,
  frq_out_if.source  dout,
  frq_cfg_if.sink    cfg
);

  localparam int MaxStride = ((MAX_DIM * frq_pkg::PIX_BYTES + frq_pkg::ROW_ALIGN - 1)
                              / frq_pkg::ROW_ALIGN) * frq_pkg::ROW_ALIGN;
  localparam int StoreDepth = MAX_DIM * MaxStride;
  localparam int WordDepth  = StoreDepth / frq_pkg::LANES;
  localparam int WordW      = (WordDepth > 1) ? $clog2(WordDepth) : 1;
  localparam int AddrW      = WordW + 2;
  localparam int StrideW    = frq_pkg::DIM_W + 2;
  localparam int ProdW      = frq_pkg::DIM_W + StrideW;

  localparam int DW = frq_pkg::DIM_W;
  localparam int CW = frq_pkg::COORD_W;
  localparam int BW = frq_pkg::BYTE_W;

  function automatic logic [DW-1:0] clamp_dim(input logic [frq_pkg::CFG_DATA_W-1:0] v);
    logic [DW-1:0] d;
    d = DW'(v);
    if (d == '0) begin
      return DW'(1);
    end else if (int'(d) > MAX_DIM) begin
      return DW'(MAX_DIM);
    end
    return d;
  endfunction

  // configuration
  logic [DW-1:0]   image_width;
  logic [DW-1:0]   image_height;
  frq_pkg::turn_t  turn_direction;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DW'(1);
      image_height   <= DW'(1);
      turn_direction <= frq_pkg::TURN_90;
    end else if (cfg.valid) begin
      case (cfg.index)
        frq_pkg::REG_WIDTH:  image_width    <= clamp_dim(cfg.data);
        frq_pkg::REG_HEIGHT: image_height   <= clamp_dim(cfg.data);
        frq_pkg::REG_TURN:   turn_direction <= frq_pkg::turn_t'(cfg.data[0]);
        default: ;
      endcase
    end
  end

  logic advance;
  assign advance   = !dout.valid || dout.ready;
  assign din.ready = advance;

  // stage 1: input register
  logic                   s1_valid;
  frq_pkg::cmd_t          s1_cmd;
  logic [CW-1:0]          s1_col;
  logic [CW-1:0]          s1_row;
  logic [BW-1:0]          s1_bytes [frq_pkg::PIX_BYTES];
  logic [CW-1:0]          s1_drow;
  logic [frq_pkg::OFS_W-1:0] s1_dbyte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd      <= frq_pkg::cmd_t'(din.command);
      s1_col      <= din.src_col;
      s1_row      <= din.src_row;
      s1_bytes[0] <= din.blue;
      s1_bytes[1] <= din.green;
      s1_bytes[2] <= din.red;
      s1_drow     <= din.dst_row;
      s1_dbyte    <= din.dst_byte;
    end
  end

  // address math
  logic [StrideW-1:0] row_bytes;
  logic [StrideW-1:0] stride;
  logic [DW-1:0]      mul_a;
  logic [StrideW-1:0] ofs;
  logic [ProdW-1:0]   prod;
  logic               s1_err;
  logic               s1_zero;
  logic [AddrW-1:0]   s1_addr;

  always_comb begin
    logic [DW-1:0] col9;
    logic [DW-1:0] row9;
    logic [DW-1:0] pix;
    col9      = DW'(s1_col);
    row9      = DW'(s1_row);
    pix       = '0;
    row_bytes = StrideW'({image_height, 1'b0}) + StrideW'(image_height);
    stride    = (row_bytes + StrideW'(frq_pkg::ROW_ALIGN - 1))
                & ~StrideW'(frq_pkg::ROW_ALIGN - 1);
    if (s1_cmd == frq_pkg::CMD_WRITE) begin
      s1_err  = (col9 >= image_width) || (row9 >= image_height);
      s1_zero = 1'b1;
      if (turn_direction == frq_pkg::TURN_90) begin
        mul_a = image_width - DW'(1) - col9;
        pix   = row9;
      end else begin
        mul_a = col9;
        pix   = image_height - DW'(1) - row9;
      end
      ofs = StrideW'({pix, 1'b0}) + StrideW'(pix);
    end else begin
      s1_err  = (DW'(s1_drow) >= image_width) || (StrideW'(s1_dbyte) >= stride);
      s1_zero = s1_err || (StrideW'(s1_dbyte) >= row_bytes);
      mul_a   = DW'(s1_drow);
      ofs     = StrideW'(s1_dbyte);
    end
    prod    = ProdW'(mul_a) * ProdW'(stride);
    s1_addr = AddrW'(prod) + AddrW'(ofs);
  end

  // stage 2: address register
  logic             s2_valid;
  frq_pkg::cmd_t    s2_cmd;
  logic             s2_err;
  logic             s2_zero;
  logic [AddrW-1:0] s2_addr;
  logic [BW-1:0]    s2_bytes [frq_pkg::PIX_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cmd   <= s1_cmd;
      s2_err   <= s1_err;
      s2_zero  <= s1_zero;
      s2_addr  <= s1_addr;
      s2_bytes <= s1_bytes;
    end
  end

  // byte lanes
  logic [1:0]       a_lo;
  logic [WordW-1:0] word0;
  logic [WordW-1:0] word1;
  logic             do_write;
  logic             do_read;
  logic [BW-1:0]    lane_rdata [frq_pkg::LANES];

  assign a_lo     = s2_addr[1:0];
  assign word0    = s2_addr[AddrW-1:2];
  assign word1    = word0 + WordW'(1);
  assign do_write = advance && s2_valid && (s2_cmd == frq_pkg::CMD_WRITE) && !s2_err;
  assign do_read  = advance && s2_valid && (s2_cmd == frq_pkg::CMD_READ) && !s2_zero;

  for (genvar k = 0; k < frq_pkg::LANES; k++) begin : g_lane
    logic [1:0]       sel;
    logic             we;
    logic [WordW-1:0] waddr;
    logic [BW-1:0]    wdata;

    assign sel   = 2'(k) - a_lo;
    assign we    = do_write && (sel != 2'd3);
    assign waddr = (2'(k) >= a_lo) ? word0 : word1;
    assign wdata = (sel == 2'd0) ? s2_bytes[0] :
                   (sel == 2'd1) ? s2_bytes[1] : s2_bytes[2];

    frq_lane_ram #(
      .DEPTH  (WordDepth),
      .ADDR_W (WordW)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (do_read),
      .raddr (word0),
      .rdata (lane_rdata[k])
    );
  end

  // output register
  logic       out_valid;
  logic       out_err;
  logic       out_zero;
  logic [1:0] out_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_err  <= s2_err;
      out_zero <= s2_zero || (s2_cmd == frq_pkg::CMD_WRITE);
      out_lane <= a_lo;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.range_error = out_err;
  assign dout.read_data   = out_zero ? '0 : lane_rdata[out_lane];

endmodule

[rtl/frq_checker.sv]
// Port-level checks for frame_rotate_quarter_turn, attached by bind.
// Depends on frq_pkg and frame_rotate_quarter_turn_macros.svh.
`timescale 1ns / 1ps
`include "frame_rotate_quarter_turn_macros.svh"

module frq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [frq_pkg::BYTE_W-1:0]  read_data,
  input logic                        range_error
);

  `FRQ_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready), "din.ready not tied to output slot")
  `FRQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(range_error), "stalled result changed")
  `FRQ_ASSERT(a_err_zero, out_valid && range_error |-> read_data == '0, "range error with nonzero data")
  `FRQ_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result item right after reset")

endmodule

bind frame_rotate_quarter_turn frq_checker u_frq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .read_data   (dout.read_data),
  .range_error (dout.range_error)
);

[bench/testbench.sv]
// Self-checking bench for the quarter-turn frame rotator: directed and random
// pixel writes and byte reads against a predicted frame, under random stalls.
// Depends on frq_pkg, the frq_if channel interfaces and frame_rotate_quarter_turn.
`timescale 1ns / 1ps

module testbench;

  localparam int PIPE_LATENCY = 3;
  localparam int MAX_STRIDE = (frq_pkg::MAX_DIM_DEFAULT * frq_pkg::PIX_BYTES
                               + frq_pkg::ROW_ALIGN - 1) / frq_pkg::ROW_ALIGN
                              * frq_pkg::ROW_ALIGN;
  localparam int STORE_BYTES = frq_pkg::MAX_DIM_DEFAULT * MAX_STRIDE;
  localparam int IDLE_PCT = 17;
  localparam logic [frq_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic [frq_pkg::COORD_W-1:0]   coord_t;
  typedef logic [frq_pkg::BYTE_W-1:0]    pix_byte_t;
  typedef logic [frq_pkg::OFS_W-1:0]     ofs_t;
  typedef logic [frq_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    frq_pkg::cmd_t command;
    coord_t        src_col;
    coord_t        src_row;
    pix_byte_t     blue;
    pix_byte_t     green;
    pix_byte_t     red;
    coord_t        dst_row;
    ofs_t          dst_byte;
  } pixel_cmd_t;

  typedef struct packed {
    pix_byte_t read_data;
    logic      range_error;
  } readout_t;

  logic clk;
  logic rst;

  frq_in_if  din();
  frq_out_if dout();
  frq_cfg_if cfg();

  frame_rotate_quarter_turn #(.MAX_DIM(frq_pkg::MAX_DIM_DEFAULT)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  // predicted frame and geometry
  pix_byte_t      frame_copy [0:STORE_BYTES-1];
  int             cur_width;
  int             cur_height;
  frq_pkg::turn_t cur_turn;

  // stimulus-side bookkeeping
  bit         byte_written [0:STORE_BYTES-1];
  int         phase_addrs [$];
  pixel_cmd_t cmd_backlog [$];
  readout_t   readout_q [$];
  pixel_cmd_t cur_cmd;
  readout_t   oldest_readout;
  int         queued_count;
  int         accepted_count;
  int         mismatch_count;
  bit         steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int stride_of(input int height);
    return (height * frq_pkg::PIX_BYTES + frq_pkg::ROW_ALIGN - 1) / frq_pkg::ROW_ALIGN
           * frq_pkg::ROW_ALIGN;
  endfunction

  function automatic int clamp_size(input int raw);
    int v;
    v = raw & 'h1ff;
    if (v == 0) return 1;
    if (v > frq_pkg::MAX_DIM_DEFAULT) return frq_pkg::MAX_DIM_DEFAULT;
    return v;
  endfunction

  function automatic int pixel_addr(input int col, input int row);
    int strd;
    strd = stride_of(cur_height);
    if (cur_turn == frq_pkg::TURN_90) begin
      return (cur_width - 1 - col) * strd + row * frq_pkg::PIX_BYTES;
    end
    return col * strd + (cur_height - 1 - row) * frq_pkg::PIX_BYTES;
  endfunction

  function automatic readout_t predict_access(input pixel_cmd_t it);
    readout_t res;
    int       strd;
    int       a;
    res = '0;
    strd = stride_of(cur_height);
    if (it.command == frq_pkg::CMD_WRITE) begin
      if (int'(it.src_col) >= cur_width || int'(it.src_row) >= cur_height) begin
        res.range_error = 1'b1;
      end else begin
        a = pixel_addr(int'(it.src_col), int'(it.src_row));
        frame_copy[a]     = it.blue;
        frame_copy[a + 1] = it.green;
        frame_copy[a + 2] = it.red;
      end
    end else begin
      if (int'(it.dst_row) >= cur_width || int'(it.dst_byte) >= strd) begin
        res.range_error = 1'b1;
      end else if (int'(it.dst_byte) < cur_height * frq_pkg::PIX_BYTES) begin
        res.read_data = frame_copy[int'(it.dst_row) * strd + int'(it.dst_byte)];
      end
    end
    return res;
  endfunction

  function automatic pixel_cmd_t rand_cmd();
    pixel_cmd_t it;
    it.command  = frq_pkg::CMD_WRITE;
    it.src_col  = coord_t'($urandom);
    it.src_row  = coord_t'($urandom);
    it.blue     = pix_byte_t'($urandom);
    it.green    = pix_byte_t'($urandom);
    it.red      = pix_byte_t'($urandom);
    it.dst_row  = coord_t'($urandom);
    it.dst_byte = ofs_t'($urandom);
    return it;
  endfunction

  task automatic queue_write(input int col, input int row, input int b, input int g,
                             input int r);
    pixel_cmd_t it;
    int         a;
    it = rand_cmd();
    it.command = frq_pkg::CMD_WRITE;
    it.src_col = coord_t'(col);
    it.src_row = coord_t'(row);
    it.blue    = pix_byte_t'(b);
    it.green   = pix_byte_t'(g);
    it.red     = pix_byte_t'(r);
    if (col < cur_width && row < cur_height) begin
      a = pixel_addr(col, row);
      byte_written[a]     = 1'b1;
      byte_written[a + 1] = 1'b1;
      byte_written[a + 2] = 1'b1;
      phase_addrs.push_back(a);
    end
    cmd_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic queue_read(input int drow, input int dbyte);
    pixel_cmd_t it;
    it = rand_cmd();
    it.command  = frq_pkg::CMD_READ;
    it.dst_row  = coord_t'(drow);
    it.dst_byte = ofs_t'(dbyte);
    cmd_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic queue_random_write();
    int col;
    int row;
    col = $urandom_range(cur_width - 1);
    row = $urandom_range(cur_height - 1);
    if ($urandom_range(99) < 12 && (cur_width < 256 || cur_height < 256)) begin
      if (cur_width < 256 && (cur_height == 256 || $urandom_range(1) == 0)) begin
        col = $urandom_range(255, cur_width);
        row = $urandom_range(255);
      end else begin
        row = $urandom_range(255, cur_height);
        col = $urandom_range(255);
      end
    end
    queue_write(col, row, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic gen_phase(input int n_items);
    int strd;
    int a;
    int r;
    int c;
    int pick;
    strd = stride_of(cur_height);
    if (cur_width * cur_height <= 64) begin
      for (r = 0; r < cur_height; r++) begin
        for (c = 0; c < cur_width; c++) begin
          queue_write(c, r, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
      end
    end
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 45 || phase_addrs.size() == 0) begin
        queue_random_write();
      end else if (pick < 75) begin
        a = phase_addrs[$urandom_range(phase_addrs.size() - 1)] + $urandom_range(2);
        queue_read(a / strd, a % strd);
      end else if (pick < 88) begin
        r = $urandom_range(cur_width - 1);
        c = $urandom_range(strd - 1);
        if (c < cur_height * frq_pkg::PIX_BYTES && !byte_written[r * strd + c]) begin
          a = phase_addrs[$urandom_range(phase_addrs.size() - 1)] + $urandom_range(2);
          r = a / strd;
          c = a % strd;
        end
        queue_read(r, c);
      end else if (pick < 92 && cur_height * frq_pkg::PIX_BYTES < strd) begin
        queue_read($urandom_range(cur_width - 1), $urandom_range(strd - 1,
                   cur_height * frq_pkg::PIX_BYTES));
      end else if (cur_width < 256 && $urandom_range(1) == 0) begin
        queue_read($urandom_range(255, cur_width), $urandom_range(1023));
      end else begin
        queue_read($urandom_range(255), $urandom_range(1023, strd));
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || readout_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    phase_addrs.delete();
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input int val, input bit last);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val[frq_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      frq_pkg::REG_WIDTH:  cur_width = clamp_size(val);
      frq_pkg::REG_HEIGHT: cur_height = clamp_size(val);
      frq_pkg::REG_TURN:   cur_turn = frq_pkg::turn_t'(val[0]);
      default: ;
    endcase
    if (last) cfg.valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
    end else begin
      if (din.valid && din.ready) begin
        readout_q.push_back(predict_access(cur_cmd));
        accepted_count++;
      end
      if (!din.valid || din.ready) begin
        if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cur_cmd = cmd_backlog.pop_front();
          din.valid    <= 1'b1;
          din.command  <= cur_cmd.command;
          din.src_col  <= cur_cmd.src_col;
          din.src_row  <= cur_cmd.src_row;
          din.blue     <= cur_cmd.blue;
          din.green    <= cur_cmd.green;
          din.red      <= cur_cmd.red;
          din.dst_row  <= cur_cmd.dst_row;
          din.dst_byte <= cur_cmd.dst_byte;
        end else begin
          din.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) begin
      if (readout_q.size() == 0) begin
        $error("result item with no expectation pending");
        mismatch_count++;
      end else begin
        oldest_readout = readout_q.pop_front();
        if (dout.read_data !== oldest_readout.read_data) begin
          report_mismatch("read_data", int'(oldest_readout.read_data),
                          int'(dout.read_data));
        end
        if (dout.range_error !== oldest_readout.range_error) begin
          report_mismatch("range_error", int'(oldest_readout.range_error),
                          int'(dout.range_error));
        end
      end
    end
    dout.ready <= steady || $urandom_range(99) >= IDLE_PCT;
  end

  initial begin
    int p;
    rst = 1'b1;
    din.valid = 1'b0;
    din.command = frq_pkg::CMD_WRITE;
    din.src_col = '0;
    din.src_row = '0;
    din.blue = '0;
    din.green = '0;
    din.red = '0;
    din.dst_row = '0;
    din.dst_byte = '0;
    dout.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = frq_pkg::REG_WIDTH;
    cfg.data = '0;
    cur_width = 1;
    cur_height = 1;
    cur_turn = frq_pkg::TURN_90;
    steady = 1'b0;
    queued_count = 0;
    accepted_count = 0;
    mismatch_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: 1x1, stride 4 with one pad byte
    queue_write(0, 0, 255, 0, 170);
    queue_read(0, 0);
    queue_read(0, 1);
    queue_read(0, 2);
    queue_read(0, 3);
    queue_read(0, 4);
    queue_read(1, 0);
    queue_write(1, 0, 1, 2, 3);
    queue_write(0, 1, 1, 2, 3);
    queue_write(255, 255, 1, 2, 3);
    wait_drained();

    write_cfg(frq_pkg::REG_WIDTH, 256, 1'b0);
    write_cfg(frq_pkg::REG_HEIGHT, 256, 1'b0);
    write_cfg(frq_pkg::REG_TURN, int'(frq_pkg::TURN_270), 1'b1);
    queue_write(255, 255, 255, 255, 255);
    queue_write(0, 0, 0, 128, 127);
    queue_write(0, 255, 1, 2, 4);
    queue_write(255, 0, 16, 32, 64);
    queue_read(pixel_addr(255, 255) / MAX_STRIDE, pixel_addr(255, 255) % MAX_STRIDE);
    queue_read(0, pixel_addr(0, 0) % MAX_STRIDE + 2);
    queue_read(0, 0);
    queue_read(255, 766);
    queue_read(0, 768);
    queue_read(255, 1023);
    gen_phase(150);
    wait_drained();

    // sizes saturate: 0 -> 1, 511 -> 256; spare index must be ignored
    write_cfg(frq_pkg::REG_WIDTH, 0, 1'b0);
    write_cfg(frq_pkg::REG_HEIGHT, 511, 1'b0);
    write_cfg(frq_pkg::REG_TURN, int'(frq_pkg::TURN_90), 1'b0);
    write_cfg(REG_SPARE, 5, 1'b1);
    gen_phase(150);
    wait_drained();

    write_cfg(frq_pkg::REG_WIDTH, 300, 1'b0);
    write_cfg(frq_pkg::REG_HEIGHT, 1, 1'b0);
    write_cfg(frq_pkg::REG_TURN, int'(frq_pkg::TURN_270), 1'b1);
    gen_phase(150);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      write_cfg(frq_pkg::REG_WIDTH, $urandom_range(12, 1), 1'b0);
      write_cfg(frq_pkg::REG_HEIGHT, $urandom_range(12, 1), 1'b0);
      write_cfg(frq_pkg::REG_TURN, $urandom_range(1), 1'b1);
      steady = (p == 2);
      gen_phase(140);
      wait_drained();
      steady = 1'b0;
    end

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/frq_pkg.sv
rtl/frq_if.sv
rtl/frq_lane_ram.sv
rtl/frame_rotate_quarter_turn.sv
rtl/frq_checker.sv
bench/testbench.sv
